// ===== rtl/smodf_pkg.sv =====
// Shared types, constants and byte helpers for the striped delta filter.
package smodf_pkg;

   localparam int MAX_LANES  = 16;
   localparam int MAX_ORDER  = 4;
   localparam int LANE_W     = $clog2(MAX_LANES);
   localparam int LANE_CNT_W = $clog2(MAX_LANES + 1);
   localparam int ORD_W      = $clog2(MAX_ORDER + 1);
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_FORMAT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LANE_COUNT    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER         = 8'd3;

   // Sample formats
   localparam logic [3:0] FMT_INT8  = 4'd0;
   localparam logic [3:0] FMT_16BE  = 4'd1;
   localparam logic [3:0] FMT_16LE  = 4'd2;
   localparam logic [3:0] FMT_24BE  = 4'd3;
   localparam logic [3:0] FMT_24LE  = 4'd4;
   localparam logic [3:0] FMT_32BE  = 4'd5;
   localparam logic [3:0] FMT_32LE  = 4'd6;
   localparam logic [3:0] FMT_48BE  = 4'd7;
   localparam logic [3:0] FMT_48LE  = 4'd8;
   localparam logic [3:0] FMT_64BE  = 4'd9;
   localparam logic [3:0] FMT_64LE  = 4'd10;

   typedef struct packed {
      logic [63:0] sample_bytes;
      logic        last_of_buffer;
   } req_type;

   typedef struct packed {
      logic [63:0] result_bytes;
      logic        result_last;
   } rsp_type;

   typedef struct packed {
      logic       direction;
      logic [3:0] sample_format;
      logic [4:0] lane_count;
      logic [2:0] order;
   } cfg_type;

   typedef logic [MAX_ORDER-1:0][63:0] hist_row_type;

   // Sample size in bytes; zero marks an unsupported format.
   function automatic logic [3:0] format_bytes(input logic [3:0] fmt);
      logic [3:0] n;
      unique case (fmt)
         FMT_INT8:           n = 4'd1;
         FMT_16BE, FMT_16LE: n = 4'd2;
         FMT_24BE, FMT_24LE: n = 4'd3;
         FMT_32BE, FMT_32LE: n = 4'd4;
         FMT_48BE, FMT_48LE: n = 4'd6;
         FMT_64BE, FMT_64LE: n = 4'd8;
         default:            n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [63:0] width_mask(input logic [3:0] n);
      logic [63:0] m;
      for (int k = 0; k < 8; k++) begin
         m[k*8 +: 8] = (4'(k) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // Swap the low n bytes end for end; clear the rest.
   function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input logic [3:0] n);
      logic [63:0] r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         for (int m = 0; m < 8; m++) begin
            if ((4'(k) < n) && (4'(m + k + 1) == n)) begin
               r[m*8 +: 8] = v[k*8 +: 8];
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/smodf_cascade.sv =====
// Byte assembly, difference or running-sum cascade, and repacking for one sample.
module smodf_cascade (
   input  smodf_pkg::cfg_type      cfg,
   input  logic [63:0]             sample,
   input  smodf_pkg::hist_row_type row_rd,
   output smodf_pkg::hist_row_type row_wr,
   output logic [63:0]             result,
   output logic                    fmt_ok
);
   import smodf_pkg::*;

   logic [3:0]       nbytes;
   logic [63:0]      mask;
   logic             big;
   logic [ORD_W-1:0] rounds;
   logic [63:0]      t;
   logic [63:0]      w;

   always_comb begin
      nbytes = format_bytes(cfg.sample_format);
      fmt_ok = (nbytes != 4'd0);
      mask   = width_mask(nbytes);
      big    = cfg.sample_format[0];
      rounds = (32'(cfg.order) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(cfg.order);

      t = sample & mask;
      if (big) begin
         t = reverse_bytes(t, nbytes);
      end

      row_wr = row_rd;
      w      = '0;
      for (int j = 0; j < MAX_ORDER; j++) begin
         if (ORD_W'(j) < rounds) begin
            if (cfg.direction) begin
               w         = (t + row_rd[j]) & mask;
               row_wr[j] = w;
            end else begin
               w         = (t - row_rd[j]) & mask;
               row_wr[j] = t;
            end
            t = w;
         end
      end

      if (!fmt_ok) begin
         result = '0;
      end else if (big) begin
         result = reverse_bytes(t, nbytes);
      end else begin
         result = t & mask;
      end
   end

endmodule

// ===== rtl/striped_multi_order_delta_filter.sv =====
// Top level of the striped multi-order delta filter.
//
//   port group   dir   handshake               payload
//   req_*        in    req_valid / req_stall   req_data   (sample, last flag)
//   rsp_*        out   rsp_valid / rsp_stall   rsp_data   (coded sample, last flag)
//   csr_*        in    csr_valid / csr_ready   csr_index, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; items pass the input register, then the result register.
// The per-lane history sits in flip-flops, read and rewritten in the cycle the item
// leaves the input register, so the order-deep add chain sets the cycle time.
// Reset is synchronous and clears history, lane counter and both valid flags at once.
// req_stall rises only when both registers are full and rsp_stall is high.
module striped_multi_order_delta_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  smodf_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output smodf_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smodf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smodf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import smodf_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   req_type             in_ff;
   logic                in_valid_ff, in_valid_in;
   rsp_type             out_ff;
   logic                out_valid_ff, out_valid_in;
   hist_row_type        hist_ff [MAX_LANES];
   logic [LANE_W-1:0]   lane_ff, lane_in;

   logic                  accept;
   logic                  move;
   logic [LANE_CNT_W-1:0] lanes;
   logic [LANE_W-1:0]     lane_sel;
   logic [LANE_CNT_W-1:0] lane_inc;
   hist_row_type          row_wr;
   logic [63:0]           result;
   logic                  fmt_ok;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIRECTION:     cfg_in.direction     = csr_wdata[0];
            CSR_SAMPLE_FORMAT: cfg_in.sample_format = csr_wdata[3:0];
            CSR_LANE_COUNT:    cfg_in.lane_count    = csr_wdata[4:0];
            CSR_ORDER:         cfg_in.order         = csr_wdata[2:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Handshake: the result register frees the input register whenever it drains.
   assign move         = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !move;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && rsp_stall);

   // Lane choice: clamp the count, fall back to lane 0 when the counter is out of range.
   always_comb begin
      if (cfg_ff.lane_count == 5'd0) begin
         lanes = LANE_CNT_W'(1);
      end else if (32'(cfg_ff.lane_count) > MAX_LANES) begin
         lanes = LANE_CNT_W'(MAX_LANES);
      end else begin
         lanes = LANE_CNT_W'(cfg_ff.lane_count);
      end
      lane_sel = (LANE_CNT_W'(lane_ff) < lanes) ? lane_ff : '0;
      lane_inc = LANE_CNT_W'(lane_sel) + LANE_CNT_W'(1);
      lane_in  = (lane_inc >= lanes) ? '0 : LANE_W'(lane_inc);
   end

   smodf_cascade u_cascade (
      .cfg    (cfg_ff),
      .sample (in_ff.sample_bytes),
      .row_rd (hist_ff[lane_sel]),
      .row_wr (row_wr),
      .result (result),
      .fmt_ok (fmt_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction     <= 1'b0;
         cfg_ff.sample_format <= FMT_INT8;
         cfg_ff.lane_count    <= 5'd1;
         cfg_ff.order         <= 3'd1;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         lane_ff              <= '0;
         for (int i = 0; i < MAX_LANES; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (move) begin
            if (in_ff.last_of_buffer) begin
               // drop all history at the end of a buffer
               lane_ff <= '0;
               for (int i = 0; i < MAX_LANES; i++) begin
                  hist_ff[i] <= '0;
               end
            end else if (fmt_ok) begin
               lane_ff           <= lane_in;
               hist_ff[lane_sel] <= row_wr;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (move) begin
         out_ff.result_bytes <= result;
         out_ff.result_last  <= in_ff.last_of_buffer;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_last_clears_lane: assert property (@(posedge clock) disable iff (reset)
      move && in_ff.last_of_buffer |=> lane_ff == '0)
      else $error("lane counter not cleared after last item");

   a_move_loads_output: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid)
      else $error("result register not loaded on move");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled while a register is free");

   a_bad_format_zero: assert property (@(posedge clock) disable iff (reset)
      move && !fmt_ok |=> rsp_data.result_bytes == '0)
      else $error("unsupported format gave a non-zero result");
`endif

endmodule
